// ===== rtl/core/mbps_pkg.sv =====
package mbps_pkg;

  // Field and register widths fixed by the block's interface
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PAT_W      = 64;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned BASE_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned OUT_ADDR_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Parameter defaults
  localparam int unsigned MAX_PATTERN_BYTES_DEF = 16;
  localparam int unsigned ADDRESS_BITS_DEF      = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CARE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd4;

  // Register reset values
  localparam logic [MASK_W-1:0] CARE_RESET   = 16'hFFFF;
  localparam logic [LEN_W-1:0]  LENGTH_RESET = 5'd1;

  // Pattern configuration seen by the compare logic
  typedef struct packed {
    logic [PAT_W-1:0]  pat_low;
    logic [PAT_W-1:0]  pat_high;
    logic [MASK_W-1:0] care;
    logic [LEN_W-1:0]  length;
    logic [BASE_W-1:0] base;
  } mbps_cfg_t;

  // Scan state handed from the window to the compare logic
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             reported;
  } mbps_scan_t;

endpackage

// ===== rtl/core/mbps_window.sv =====
module mbps_window
  import mbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic [BYTE_W-1:0]                      data_byte_i,
  input  logic                                   last_byte_i,
  input  logic                                   hit_i,
  output logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] window_o,
  output mbps_scan_t                             scan_o
);

  logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] window_q, window_d;
  logic [CNT_W-1:0]                         count_q, count_d, count_inc;
  logic                                     reported_q, reported_d;

  // Shift the new byte in at the newest end
  always_comb begin
    window_d[0] = data_byte_i;
    for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
      window_d[j] = window_q[j-1];
    end
  end

  // Count bytes of this region, saturating at the top
  assign count_inc = (count_q == '1) ? count_q : count_q + CNT_W'(1);

  assign window_o        = window_d;
  assign scan_o.count    = count_inc;
  assign scan_o.reported = reported_q;

  // Rearm on the final byte, otherwise advance while no match is reported
  always_comb begin
    count_d    = count_q;
    reported_d = reported_q;
    if (accept_i) begin
      if (last_byte_i) begin
        count_d    = '0;
        reported_d = 1'b0;
      end else if (!reported_q) begin
        count_d    = count_inc;
        reported_d = hit_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      reported_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      reported_q <= reported_d;
    end
  end

  // Window contents need no reset: the byte count gates every compare
  always_ff @(posedge clk_i) begin
    if (accept_i && !reported_q) begin
      window_q <= window_d;
    end
  end

endmodule

// ===== rtl/core/mbps_match.sv =====
module mbps_match
  import mbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int unsigned ADDRESS_BITS      = ADDRESS_BITS_DEF
) (
  input  logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] window_i,
  input  mbps_scan_t                             scan_i,
  input  mbps_cfg_t                              cfg_i,
  output logic                                   hit_o,
  output logic [OUT_ADDR_W-1:0]                  addr_o
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_PATTERN_BYTES);
  localparam logic [OUT_ADDR_W-1:0] AddrMask = (ADDRESS_BITS >= OUT_ADDR_W) ?
      {OUT_ADDR_W{1'b1}} : OUT_ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

  logic [2*PAT_W-1:0]  pattern;
  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    span;
  logic                bytes_ok;
  logic [CNT_W-1:0]    offset;
  logic [OUT_ADDR_W-1:0] sum;

  assign pattern = {cfg_i.pat_high, cfg_i.pat_low};

  // Clamp the length to the window; an empty pattern still spans one byte
  assign len      = (cfg_i.length > MaxLen) ? MaxLen : cfg_i.length;
  assign span     = (len == '0) ? LEN_W'(1) : len;
  assign bytes_ok = scan_i.count >= CNT_W'(span);

  // Compare each pattern byte against its window slot; byte i sits at len-1-i
  always_comb begin
    logic             all_ok;
    logic [LEN_W-1:0] pos;
    logic [BYTE_W-1:0] sel;
    all_ok = 1'b1;
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      pos = len - LEN_W'(1) - LEN_W'(i);
      sel = '0;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
        if (pos == LEN_W'(j)) begin
          sel = window_i[j];
        end
      end
      if ((LEN_W'(i) < len) && cfg_i.care[i] &&
          (sel != pattern[i*BYTE_W +: BYTE_W])) begin
        all_ok = 1'b0;
      end
    end
    hit_o = bytes_ok && all_ok;
  end

  // Start address: base plus offset, wrapped to the address space
  assign offset = scan_i.count - CNT_W'(span);
  assign sum    = OUT_ADDR_W'(cfg_i.base) + OUT_ADDR_W'(offset);
  assign addr_o = sum & AddrMask;

endmodule

// ===== rtl/core/mbps_result_buf.sv =====
module mbps_result_buf
  import mbps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  found_i,
  input  logic [OUT_ADDR_W-1:0] addr_i,
  output logic                  full_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic [OUT_ADDR_W-1:0] match_address_o
);

  logic                  found_q [2];
  logic [OUT_ADDR_W-1:0] addr_q  [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            fill_q, fill_d;
  logic                  pop;

  assign out_valid_o     = fill_q != 2'd0;
  assign full_o          = fill_q == 2'd2;
  assign pop             = out_valid_o && out_ready_i;
  assign found_o         = found_q[rd_ptr_q];
  assign match_address_o = addr_q[rd_ptr_q];

  // Track occupancy of the two result slots
  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // Store the result payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      found_q[wr_ptr_q] <= found_i;
      addr_q[wr_ptr_q]  <= addr_i;
    end
  end

endmodule

// ===== rtl/core/masked_byte_pattern_scan.sv =====
// Channel   Direction  Handshake                     Payload
// -------   ---------  ----------------------------  -------------------------------
// input     in         in_valid_i / in_ready_o       data_byte_i, last_byte_i
// result    out        out_valid_o / out_ready_i     found_o, match_address_o
// config    in         cfg_we_i (no wait)            cfg_index_i, cfg_data_i
//
// One byte transfer per cycle while in_ready_o is high; the result of a byte is
// registered in the result buffer and shows once any older result has left.
// The window compare is combinational logic.
// A two-entry result buffer lets the input keep moving while a result waits;
// input stalls only when both entries are held.
// Reset clears the scan state, the result buffer and the registers to defaults.
module masked_byte_pattern_scan
  import mbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF,
  parameter int unsigned ADDRESS_BITS      = ADDRESS_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic [OUT_ADDR_W-1:0] match_address_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  mbps_cfg_t cfg_q;
  mbps_scan_t scan;
  logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] window;
  logic                  accept;
  logic                  hit;
  logic [OUT_ADDR_W-1:0] hit_addr;
  logic                  push;
  logic                  full;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pat_low  <= '0;
      cfg_q.pat_high <= '0;
      cfg_q.care     <= CARE_RESET;
      cfg_q.length   <= LENGTH_RESET;
      cfg_q.base     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PAT_LOW:  cfg_q.pat_low  <= cfg_data_i[PAT_W-1:0];
        CFG_PAT_HIGH: cfg_q.pat_high <= cfg_data_i[PAT_W-1:0];
        CFG_CARE:     cfg_q.care     <= cfg_data_i[MASK_W-1:0];
        CFG_LENGTH:   cfg_q.length   <= cfg_data_i[LEN_W-1:0];
        CFG_BASE:     cfg_q.base     <= cfg_data_i[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  // Report a hit, or not found on the final byte, while no match is reported
  assign push = accept && !scan.reported && (hit || last_byte_i);

  mbps_window #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .hit_i      (hit),
    .window_o   (window),
    .scan_o     (scan)
  );

  mbps_match #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
    .ADDRESS_BITS     (ADDRESS_BITS)
  ) u_match (
    .window_i(window),
    .scan_i  (scan),
    .cfg_i   (cfg_q),
    .hit_o   (hit),
    .addr_o  (hit_addr)
  );

  mbps_result_buf u_result_buf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .found_i        (hit),
    .addr_i         (hit ? hit_addr : '0),
    .full_o         (full),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .match_address_o(match_address_o)
  );

endmodule
